// ===== hdl/swd_hte_pkg.sv =====
package swd_hte_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_LRST  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_WAIT     = 3'd1;
    localparam logic [2:0] ST_FAULT    = 3'd2;
    localparam logic [2:0] ST_BAD_ACK  = 3'd3;
    localparam logic [2:0] ST_PARITY   = 3'd4;
    localparam logic [2:0] ST_REJECTED = 3'd5;

    localparam logic [2:0] ACK_OK    = 3'b001;
    localparam logic [2:0] ACK_WAIT  = 3'b010;
    localparam logic [2:0] ACK_FAULT = 3'b100;

    localparam logic [7:0]  REQ_BASE_READ  = 8'b1000_0101;
    localparam logic [7:0]  REQ_BASE_WRITE = 8'b1000_0001;
    localparam logic [15:0] LRST_PATTERN   = 16'hE79E;

    localparam logic [6:0] REQ_BITS       = 7'd8;
    localparam logic [6:0] ACK_BITS       = 7'd3;
    localparam logic [6:0] DATA_BITS      = 7'd32;
    localparam logic [6:0] LRST_ONES_END  = 7'd50;
    localparam logic [6:0] LRST_PAT_END   = 7'd66;
    localparam logic [6:0] LRST_ONES2_END = 7'd116;
    localparam logic [6:0] LRST_BITS      = 7'd119;

    localparam int unsigned CFG_IDX_IDLE = 0;
    localparam int unsigned CFG_IDX_TRN  = 1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_REQ,
        PH_TRN1,
        PH_ACK,
        PH_RDATA,
        PH_RPAR,
        PH_TRN2,
        PH_WDATA,
        PH_WPAR,
        PH_TAIL,
        PH_TRNERR,
        PH_LRST
    } phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        ap_not_dp;
        logic [1:0]  reg_addr;
        logic [31:0] write_data;
        logic        sampled_bit;
    } cmd_t;

    typedef struct packed {
        logic        line_out;
        logic        line_drive;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  status;
        logic [2:0]  ack_bits;
        logic [31:0] read_data;
    } rsp_t;

    typedef struct packed {
        phase_t      phase;
        logic [6:0]  bit_count;
        logic [31:0] data_shift;
        logic [7:0]  request_byte;
        logic        parity_acc;
        logic [2:0]  ack_shift;
        logic        is_write;
    } eng_state_t;

    typedef struct packed {
        logic [3:0] idle_cycles;
        logic [2:0] turnaround_cycles;
    } cfg_t;

endpackage

// ===== hdl/swd_hte_step.sv =====
module swd_hte_step (
    input  swd_hte_pkg::eng_state_t state,
    input  swd_hte_pkg::cmd_t       cmd,
    input  swd_hte_pkg::cfg_t       cfg,
    output swd_hte_pkg::eng_state_t state_next,
    output swd_hte_pkg::rsp_t       rsp
);

    always_comb
    begin
        swd_hte_pkg::eng_state_t mid;
        swd_hte_pkg::eng_state_t nxt;
        swd_hte_pkg::rsp_t       res;
        logic       rnw;
        logic       req_par;
        logic       rejected;
        logic       fin;
        logic       fin_ok;
        logic       end_d;
        logic [2:0] fin_code;
        logic [2:0] fin_ack;
        logic [31:0] fin_data;
        logic [6:0] bc_inc;
        logic [6:0] trn_len;
        logic [6:0] idle_len;
        logic [6:0] pat_off;
        logic [2:0] ack_new;
        logic       wbit;

        mid      = state;
        res      = '0;
        rejected = 1'b0;
        fin      = 1'b0;
        fin_ok   = 1'b0;
        end_d    = 1'b0;
        fin_code = swd_hte_pkg::ST_OK;
        fin_ack  = 3'd0;
        fin_data = 32'd0;
        rnw      = (cmd.action == swd_hte_pkg::ACT_READ);
        req_par  = cmd.ap_not_dp ^ rnw ^ cmd.reg_addr[0] ^ cmd.reg_addr[1];

        if (state.phase == swd_hte_pkg::PH_IDLE)
        begin
            unique case (cmd.action)
                swd_hte_pkg::ACT_READ, swd_hte_pkg::ACT_WRITE:
                begin
                    mid.request_byte = (rnw ? swd_hte_pkg::REQ_BASE_READ
                                            : swd_hte_pkg::REQ_BASE_WRITE)
                                       | {2'b00, req_par, cmd.reg_addr, 1'b0,
                                          cmd.ap_not_dp, 1'b0};
                    mid.is_write   = ~rnw;
                    mid.data_shift = rnw ? 32'd0 : cmd.write_data;
                    mid.parity_acc = 1'b0;
                    mid.ack_shift  = 3'd0;
                    mid.phase      = swd_hte_pkg::PH_REQ;
                    mid.bit_count  = 7'd0;
                end
                swd_hte_pkg::ACT_LRST:
                begin
                    mid.ack_shift  = 3'd0;
                    mid.parity_acc = 1'b0;
                    mid.phase      = swd_hte_pkg::PH_LRST;
                    mid.bit_count  = 7'd0;
                end
                default:
                begin
                    mid = state;
                end
            endcase
        end
        else if (cmd.action != swd_hte_pkg::ACT_TICK)
        begin
            rejected = 1'b1;
        end

        nxt      = mid;
        bc_inc   = mid.bit_count + 7'd1;
        trn_len  = (cfg.turnaround_cycles == 3'd0) ? 7'd1
                                                   : {4'd0, cfg.turnaround_cycles};
        idle_len = {3'd0, cfg.idle_cycles};
        pat_off  = mid.bit_count - swd_hte_pkg::LRST_ONES_END;
        ack_new  = mid.ack_shift;
        wbit     = 1'b0;

        if (mid.phase == swd_hte_pkg::PH_IDLE)
        begin
            res.line_drive = 1'b1;
        end
        else
        begin
            res.busy_res  = 1'b1;
            nxt.bit_count = bc_inc;
            unique case (mid.phase)
                swd_hte_pkg::PH_REQ:
                begin
                    res.line_out   = mid.request_byte[mid.bit_count[2:0]];
                    res.line_drive = 1'b1;
                    if (bc_inc >= swd_hte_pkg::REQ_BITS)
                    begin
                        nxt.phase     = swd_hte_pkg::PH_TRN1;
                        nxt.bit_count = 7'd0;
                    end
                end
                swd_hte_pkg::PH_TRN1:
                begin
                    if (bc_inc >= trn_len)
                    begin
                        nxt.phase     = swd_hte_pkg::PH_ACK;
                        nxt.bit_count = 7'd0;
                    end
                end
                swd_hte_pkg::PH_ACK:
                begin
                    case (mid.bit_count[1:0])
                        2'd0:    ack_new[0] = ack_new[0] | cmd.sampled_bit;
                        2'd1:    ack_new[1] = ack_new[1] | cmd.sampled_bit;
                        2'd2:    ack_new[2] = ack_new[2] | cmd.sampled_bit;
                        default: ack_new = mid.ack_shift;
                    endcase
                    nxt.ack_shift = ack_new;
                    if (bc_inc >= swd_hte_pkg::ACK_BITS)
                    begin
                        nxt.bit_count = 7'd0;
                        if (ack_new != swd_hte_pkg::ACK_OK)
                            nxt.phase = swd_hte_pkg::PH_TRNERR;
                        else if (mid.is_write)
                            nxt.phase = swd_hte_pkg::PH_TRN2;
                        else
                            nxt.phase = swd_hte_pkg::PH_RDATA;
                    end
                end
                swd_hte_pkg::PH_RDATA:
                begin
                    nxt.data_shift = {cmd.sampled_bit, mid.data_shift[31:1]};
                    nxt.parity_acc = mid.parity_acc ^ cmd.sampled_bit;
                    if (bc_inc >= swd_hte_pkg::DATA_BITS)
                    begin
                        nxt.phase     = swd_hte_pkg::PH_RPAR;
                        nxt.bit_count = 7'd0;
                    end
                end
                swd_hte_pkg::PH_RPAR:
                begin
                    nxt.parity_acc = mid.parity_acc ^ cmd.sampled_bit;
                    nxt.phase      = swd_hte_pkg::PH_TRN2;
                    nxt.bit_count  = 7'd0;
                end
                swd_hte_pkg::PH_TRN2:
                begin
                    if (bc_inc >= trn_len)
                    begin
                        nxt.bit_count = 7'd0;
                        if (mid.is_write)
                            nxt.phase = swd_hte_pkg::PH_WDATA;
                        else
                            end_d = 1'b1;
                    end
                end
                swd_hte_pkg::PH_WDATA:
                begin
                    wbit           = mid.data_shift[0];
                    res.line_out   = wbit;
                    res.line_drive = 1'b1;
                    nxt.parity_acc = mid.parity_acc ^ wbit;
                    nxt.data_shift = {1'b0, mid.data_shift[31:1]};
                    if (bc_inc >= swd_hte_pkg::DATA_BITS)
                    begin
                        nxt.phase     = swd_hte_pkg::PH_WPAR;
                        nxt.bit_count = 7'd0;
                    end
                end
                swd_hte_pkg::PH_WPAR:
                begin
                    res.line_out   = mid.parity_acc;
                    res.line_drive = 1'b1;
                    nxt.parity_acc = 1'b0;
                    nxt.bit_count  = 7'd0;
                    end_d          = 1'b1;
                end
                swd_hte_pkg::PH_TAIL:
                begin
                    res.line_drive = 1'b1;
                    if (bc_inc >= idle_len)
                        fin_ok = 1'b1;
                end
                swd_hte_pkg::PH_TRNERR:
                begin
                    if (bc_inc >= trn_len)
                    begin
                        fin     = 1'b1;
                        fin_ack = mid.ack_shift;
                        if (mid.ack_shift == swd_hte_pkg::ACK_WAIT)
                            fin_code = swd_hte_pkg::ST_WAIT;
                        else if (mid.ack_shift == swd_hte_pkg::ACK_FAULT)
                            fin_code = swd_hte_pkg::ST_FAULT;
                        else
                            fin_code = swd_hte_pkg::ST_BAD_ACK;
                    end
                end
                swd_hte_pkg::PH_LRST:
                begin
                    res.line_drive = 1'b1;
                    if (mid.bit_count < swd_hte_pkg::LRST_ONES_END)
                        res.line_out = 1'b1;
                    else if (mid.bit_count < swd_hte_pkg::LRST_PAT_END)
                        res.line_out = swd_hte_pkg::LRST_PATTERN[pat_off[3:0]];
                    else if (mid.bit_count < swd_hte_pkg::LRST_ONES2_END)
                        res.line_out = 1'b1;
                    else
                        res.line_out = 1'b0;
                    if (bc_inc >= swd_hte_pkg::LRST_BITS)
                        fin = 1'b1;
                end
                default:
                begin
                    nxt.phase     = swd_hte_pkg::PH_IDLE;
                    nxt.bit_count = 7'd0;
                end
            endcase
        end

        if (end_d)
        begin
            if (cfg.idle_cycles == 4'd0)
                fin_ok = 1'b1;
            else
                nxt.phase = swd_hte_pkg::PH_TAIL;
        end

        if (fin_ok)
        begin
            fin     = 1'b1;
            fin_ack = nxt.ack_shift;
            if (nxt.is_write)
            begin
                fin_code = swd_hte_pkg::ST_OK;
                fin_data = 32'd0;
            end
            else
            begin
                fin_code = nxt.parity_acc ? swd_hte_pkg::ST_PARITY : swd_hte_pkg::ST_OK;
                fin_data = nxt.data_shift;
            end
        end

        if (fin)
        begin
            res.done_res  = 1'b1;
            res.status    = fin_code;
            res.ack_bits  = fin_ack;
            res.read_data = fin_data;
            nxt.phase     = swd_hte_pkg::PH_IDLE;
            nxt.bit_count = 7'd0;
        end
        else if (rejected)
        begin
            res.status = swd_hte_pkg::ST_REJECTED;
        end

        state_next = nxt;
        rsp        = res;
    end

endmodule

// ===== hdl/swd_host_transaction_engine.sv =====
// Channel   Direction  Handshake               Payload
// cmd       in         cmd_valid / cmd_ready   swd_hte_pkg::cmd_t, one SWCLK tick
// rsp       out        rsp_valid / rsp_ready   swd_hte_pkg::rsp_t, one per tick
// cfg       in         cfg_we                  cfg_addr selects, cfg_wdata value
//
// Each transfer is held in an input register, stepped through the engine state
// combinationally and written to a result register, so one tick is taken per
// clock while the result register is empty or rsp_ready is high.
// When the result register is held by rsp_ready low, one further tick waits in the
// input register before cmd_ready drops.
// Reset is asynchronous and active low; it returns the engine to idle with
// the default idle and turnaround counts.
module swd_host_transaction_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  swd_hte_pkg::cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output swd_hte_pkg::rsp_t rsp,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [3:0]        cfg_wdata
);

    logic                    cmd_valid_reg;
    swd_hte_pkg::cmd_t       cmd_reg;
    logic                    rsp_valid_reg;
    swd_hte_pkg::rsp_t       rsp_reg;
    swd_hte_pkg::eng_state_t state_reg;
    swd_hte_pkg::eng_state_t state_next;
    swd_hte_pkg::rsp_t       step_rsp;
    swd_hte_pkg::cfg_t       cfg_reg;
    logic                    advance;

    assign advance   = cmd_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !cmd_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    swd_hte_step u_step (
        .state      (state_reg),
        .cmd        (cmd_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .rsp        (step_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_cycles       <= 4'd3;
            cfg_reg.turnaround_cycles <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                1'(swd_hte_pkg::CFG_IDX_IDLE): cfg_reg.idle_cycles       <= cfg_wdata;
                1'(swd_hte_pkg::CFG_IDX_TRN):  cfg_reg.turnaround_cycles <= cfg_wdata[2:0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cmd_ready)
                cmd_valid_reg <= cmd_valid;
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
            cmd_reg <= cmd;
        if (advance)
            rsp_reg <= step_rsp;
    end

endmodule
